// ----- rtl/spin_heading_strobe_led_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spin heading strobe LED block
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPIN_HEADING_STROBE_LED_MACROS_SVH
`define SPIN_HEADING_STROBE_LED_MACROS_SVH
`ifndef SYNTH
`define SHSL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("check failed");
`define SHSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define SHSL_ASSERT(lbl, prop)
`define SHSL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/shsl_pkg.sv -----
// ----------------------------------------------------------------------------
// Spin heading strobe LED package
// Shared types, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package shsl_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DivCntW  = 5;

  localparam logic [22:0] SpinThresholdRst   = 23'd6836;
  localparam logic [15:0] HalfWindowRst      = 16'd1825;
  localparam logic [15:0] ReferenceAngleRst  = 16'd0;
  localparam logic [31:0] StaleLimitRst      = 32'd200000;
  localparam logic [31:0] BlinkHalfPeriodRst = 32'd250000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPIN_THRESHOLD    = 3'd0,
    CFG_HALF_WINDOW       = 3'd1,
    CFG_REFERENCE_ANGLE   = 3'd2,
    CFG_STALE_LIMIT       = 3'd3,
    CFG_BLINK_HALF_PERIOD = 3'd4
  } shsl_cfg_e;

  typedef enum logic {
    OP_ESTIMATE = 1'b0,
    OP_TICK     = 1'b1
  } shsl_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_ANGLE,
    S_DIV,
    S_DONE
  } shsl_state_e;

  typedef struct packed {
    logic store_est;
    logic capture;
    logic eval;
    logic mul;
    logic angle;
    logic div_step;
    logic out_load;
  } shsl_cmd_t;

  typedef struct packed {
    logic strobe;
    logic div_last;
  } shsl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/shsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// Spin heading strobe LED controller
// Sequences one item at a time and owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spin_heading_strobe_led_macros.svh"

module shsl_ctrl
  import shsl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      operation_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output shsl_cmd_t      cmd_o,
  input  wire shsl_sts_t sts_i
);

  shsl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_xfer;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (operation_i == OP_TICK) begin
            cmd_o.capture = 1'b1;
            state_d       = S_EVAL;
          end else begin
            cmd_o.store_est = 1'b1;
          end
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.strobe ? S_MUL : S_DIV;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ANGLE;
      end
      S_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = S_DONE;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  `SHSL_ASSERT_NEXT(a_tick_starts_eval, in_xfer && operation_i == OP_TICK, state_q == S_EVAL)
  `SHSL_ASSERT_NEXT(a_est_stays_idle, in_xfer && operation_i == OP_ESTIMATE, state_q == S_IDLE)
  `SHSL_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready_i, out_valid_q)
  `SHSL_ASSERT(a_load_when_free, !cmd_o.out_load || !out_valid_q || out_ready_i)

endmodule

`default_nettype wire

// ----- rtl/shsl_dp.sv -----
// ----------------------------------------------------------------------------
// Spin heading strobe LED datapath
// Holds the configuration, the stored estimate, the angle arithmetic and
// a one-bit-per-cycle divider for the heartbeat.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spin_heading_strobe_led_macros.svh"

module shsl_dp
  import shsl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic [31:0]         now_us_i,
  input  wire logic signed [15:0]  heading_i,
  input  wire logic signed [23:0]  omega_i,
  input  wire shsl_cmd_t           cmd_i,
  output shsl_sts_t                sts_o,
  output logic                     led_on_o,
  output logic                     spinning_o
);

  logic [22:0] thr_q;
  logic [15:0] half_win_q;
  logic [15:0] ref_ang_q;
  logic [31:0] stale_q;
  logic [31:0] blink_hp_q;

  logic [15:0] head_q;
  logic [23:0] rate_q;
  logic [31:0] est_time_q;
  logic        est_valid_q;

  logic [31:0] now_q;
  logic [31:0] dt_q;
  logic [31:0] prod_q;
  logic        strobe_q;
  logic        lit_q;
  logic        led_q;
  logic        spin_q;

  logic [31:0]        num_q;
  logic [31:0]        rem_q;
  logic [DivCntW-1:0] cnt_q;

  logic [31:0] dt_d;
  logic [23:0] mag;
  logic        strobe_d;
  logic [31:0] rate_ext;
  logic [31:0] acc;
  logic [15:0] ang;
  logic [16:0] ang_mag;
  logic [31:0] hp;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= SpinThresholdRst;
      half_win_q <= HalfWindowRst;
      ref_ang_q  <= ReferenceAngleRst;
      stale_q    <= StaleLimitRst;
      blink_hp_q <= BlinkHalfPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SPIN_THRESHOLD:    thr_q      <= cfg_data_i[22:0];
        CFG_HALF_WINDOW:       half_win_q <= cfg_data_i[15:0];
        CFG_REFERENCE_ANGLE:   ref_ang_q  <= cfg_data_i[15:0];
        CFG_STALE_LIMIT:       stale_q    <= cfg_data_i;
        CFG_BLINK_HALF_PERIOD: blink_hp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      rate_q      <= '0;
      est_time_q  <= '0;
      est_valid_q <= 1'b0;
    end else if (cmd_i.store_est) begin
      head_q      <= heading_i;
      rate_q      <= omega_i;
      est_time_q  <= now_us_i;
      est_valid_q <= 1'b1;
    end
  end

  // Freshness and mode decision.
  assign dt_d     = now_q - est_time_q;
  assign mag      = rate_q[23] ? (24'd0 - rate_q) : rate_q;
  assign strobe_d = est_valid_q && (dt_d <= stale_q) && (mag > {1'b0, thr_q});

  // Only the low 32 bits of the Q16 angle matter, since one turn wraps.
  assign rate_ext = {{8{rate_q[23]}}, rate_q};
  assign acc      = {head_q, 16'h0000} + prod_q - {ref_ang_q, 16'h0000} + 32'h0000_8000;
  assign ang      = acc[31:16];
  assign ang_mag  = ang[15] ? (17'h1_0000 - {1'b0, ang}) : {1'b0, ang};

  // Restoring division step; the last quotient bit gives the parity.
  assign hp      = (blink_hp_q == 32'd0) ? 32'd1 : blink_hp_q;
  assign shifted = {rem_q, num_q[31]};
  assign diff    = shifted - {1'b0, hp};
  assign ge      = (shifted >= {1'b0, hp});

  assign sts_o.strobe   = strobe_d;
  assign sts_o.div_last = (cnt_q == {DivCntW{1'b1}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q <= now_us_i;
    end
    if (cmd_i.eval) begin
      dt_q     <= dt_d;
      strobe_q <= strobe_d;
      num_q    <= now_q;
      rem_q    <= '0;
      cnt_q    <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= rate_ext * dt_q;
    end
    if (cmd_i.angle) begin
      lit_q <= (ang_mag < {1'b0, half_win_q});
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? diff[31:0] : shifted[31:0];
      num_q <= {num_q[30:0], 1'b0};
      cnt_q <= cnt_q + DivCntW'(1);
      if (sts_o.div_last) begin
        lit_q <= !ge;
      end
    end
    if (cmd_i.out_load) begin
      led_q  <= lit_q;
      spin_q <= strobe_q;
    end
  end

  assign led_on_o   = led_q;
  assign spinning_o = spin_q;

  `SHSL_ASSERT_NEXT(a_div_restart, cmd_i.eval, cnt_q == '0)
  `SHSL_ASSERT_NEXT(a_rem_below_divisor, cmd_i.div_step, rem_q < hp)

endmodule

`default_nettype wire

// ----- rtl/spin_heading_strobe_led.sv -----
// ----------------------------------------------------------------------------
// Spin heading strobe LED
// Stores heading estimates and answers ticks with an LED decision, either
// a strobe from the extrapolated heading or an idle heartbeat.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  in       input      in_valid_i / in_ready_o    operation, now_us, heading, omega
//  out      output     out_valid_o / out_ready_i  led_on, spinning
//  cfg      input      cfg_we_i                   cfg_index_i, cfg_data_i
//
//  An estimate transfer is absorbed in its own cycle and gives no result.
//  A strobe tick steps through decide, multiply, angle and load after its transfer.
//  A heartbeat tick decides, then runs the divider, which resolves one
//  quotient bit per cycle, and then loads its result.
//  A finished result waits in the output register; a new item is taken
//  meanwhile, and the next result is held back only while that one stalls.
//  Reset restores the register defaults and clears the stored estimate.
// ----------------------------------------------------------------------------
`default_nettype none

module spin_heading_strobe_led
  import shsl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                operation_i,
  input  wire logic [31:0]         now_us_i,
  input  wire logic signed [15:0]  heading_i,
  input  wire logic signed [23:0]  omega_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     led_on_o,
  output logic                     spinning_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  shsl_cmd_t cmd;
  shsl_sts_t sts;

  shsl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  shsl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .now_us_i    (now_us_i),
    .heading_i   (heading_i),
    .omega_i     (omega_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .led_on_o    (led_on_o),
    .spinning_o  (spinning_o)
  );

endmodule

`default_nettype wire
